[rtl/mdc_pkg.sv]
// Shared types, constants and the sine table generator for the chorus block.
`default_nettype none
package mdc_pkg;

  localparam int FRAC_BITS = 16;   // Q10.16 delay fraction
  localparam int LFO_BITS  = 16;   // signed Q1.15 LFO value
  localparam int DELAY_W   = 34;   // signed working width of the delay sum
  localparam int WT_W      = 32;   // signed Q30 interpolation weight
  localparam int APB_AW    = 5;
  localparam int TAPS      = 4;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] RECIP3      = 32'hAAAA_AAAB;  // ceil(2^33 / 3)

  localparam logic [1:0] EFFECT_BYPASS   = 2'd0;
  localparam logic [1:0] EFFECT_DRY_WET  = 2'd1;
  localparam logic [1:0] EFFECT_WET_BOTH = 2'd2;
  localparam logic [1:0] EFFECT_SPARE    = 2'd3;  // unlisted, acts as wet on both

  typedef enum logic [2:0] {
    REG_MODE,
    REG_WAVE,
    REG_BASE,
    REG_SWEEP,
    REG_STEP
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  effect_mode;
    logic        wave_shape;
    logic [25:0] base_delay;
    logic [25:0] sweep_depth;
    logic [30:0] phase_step;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LFO_IDX,
    ST_LFO_VAL,
    ST_SWEEP,
    ST_DELAY,
    ST_PAIR_A,
    ST_PAIR_B,
    ST_WM1,
    ST_W0,
    ST_W1,
    ST_W2,
    ST_DIV_M1,
    ST_DIV_W2,
    ST_TAPS,
    ST_ROUND,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LFO_IDX,
    OP_LFO_VAL,
    OP_SWEEP,
    OP_DELAY,
    OP_PAIR_A,
    OP_PAIR_B,
    OP_WM1,
    OP_W0,
    OP_W1,
    OP_W2,
    OP_DIV_M1,
    OP_DIV_W2,
    OP_ROUND,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       mac_en;
    logic [1:0] mac_sel;
  } cmd_t;

  typedef struct packed {
    logic bypass;
  } sts_t;

  // Quarter-wave sine entry from a Q30 angle, Taylor series to x^13.
  function automatic logic [LFO_BITS-1:0] sine_entry(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    term = x;
    sum  = $signed(x);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 6;
    sum  = sum - $signed(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 20;
    sum  = sum + $signed(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 42;
    sum  = sum - $signed(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 72;
    sum  = sum + $signed(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 110;
    sum  = sum - $signed(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    v = ((64'(sum) << 15) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[LFO_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/mdc_regs.sv]
// APB-style configuration register file.
`default_nettype none
module mdc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mdc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output mdc_pkg::cfg_t                      cfg
);
  import mdc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.effect_mode <= EFFECT_BYPASS;
      cfg_r.wave_shape  <= 1'b0;
      cfg_r.base_delay  <= 26'd15728640;
      cfg_r.sweep_depth <= '0;
      cfg_r.phase_step  <= 31'd44238;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_MODE:  cfg_r.effect_mode <= pwdata[1:0];
        REG_WAVE:  cfg_r.wave_shape  <= pwdata[0];
        REG_BASE:  cfg_r.base_delay  <= pwdata[25:0];
        REG_SWEEP: cfg_r.sweep_depth <= pwdata[25:0];
        REG_STEP:  cfg_r.phase_step  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:  prdata = {30'd0, cfg_r.effect_mode};
      REG_WAVE:  prdata = {31'd0, cfg_r.wave_shape};
      REG_BASE:  prdata = {6'd0, cfg_r.base_delay};
      REG_SWEEP: prdata = {6'd0, cfg_r.sweep_depth};
      REG_STEP:  prdata = {1'b0, cfg_r.phase_step};
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/mdc_ctrl.sv]
// Sequencing state machine: handshakes and micro-op commands.
`default_nettype none
module mdc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  mdc_pkg::sts_t      sts,
  output mdc_pkg::cmd_t      cmd
);
  import mdc_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] tap_cnt_r, tap_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tap_cnt_nxt   = tap_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = sts.bypass ? ST_FIN : ST_LFO_IDX;
        end
      end
      ST_LFO_IDX: begin
        cmd.op    = OP_LFO_IDX;
        state_nxt = ST_LFO_VAL;
      end
      ST_LFO_VAL: begin
        cmd.op    = OP_LFO_VAL;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.op    = OP_SWEEP;
        state_nxt = ST_DELAY;
      end
      ST_DELAY: begin
        cmd.op    = OP_DELAY;
        state_nxt = ST_PAIR_A;
      end
      ST_PAIR_A: begin
        cmd.op    = OP_PAIR_A;
        state_nxt = ST_PAIR_B;
      end
      ST_PAIR_B: begin
        cmd.op    = OP_PAIR_B;
        state_nxt = ST_WM1;
      end
      ST_WM1: begin
        cmd.op    = OP_WM1;
        state_nxt = ST_W0;
      end
      ST_W0: begin
        cmd.op    = OP_W0;
        state_nxt = ST_W1;
      end
      ST_W1: begin
        cmd.op    = OP_W1;
        state_nxt = ST_W2;
      end
      ST_W2: begin
        cmd.op    = OP_W2;
        state_nxt = ST_DIV_M1;
      end
      ST_DIV_M1: begin
        cmd.op    = OP_DIV_M1;
        state_nxt = ST_DIV_W2;
      end
      ST_DIV_W2: begin
        cmd.op      = OP_DIV_W2;
        tap_cnt_nxt = '0;
        state_nxt   = ST_TAPS;
      end
      ST_TAPS: begin
        // read of tap n overlaps the accumulate of tap n-1
        cmd.rd_en   = (tap_cnt_r != 3'(TAPS));
        cmd.rd_sel  = tap_cnt_r[1:0];
        cmd.mac_en  = (tap_cnt_r != 3'd0);
        cmd.mac_sel = 2'(tap_cnt_r - 3'd1);
        if (tap_cnt_r == 3'(TAPS)) begin
          state_nxt = ST_ROUND;
        end else begin
          tap_cnt_nxt = tap_cnt_r + 3'd1;
        end
      end
      ST_ROUND: begin
        cmd.op    = OP_ROUND;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/mdc_dp.sv]
// Datapath: delay ring, LFO, delay computation, Lagrange weights and MAC.
`default_nettype none
module mdc_dp #(
  parameter int DELAY_DEPTH      = 1024,
  parameter int SAMPLE_BITS      = 24,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  mdc_pkg::cfg_t                      cfg,
  input  mdc_pkg::cmd_t                      cmd,
  output mdc_pkg::sts_t                      sts,
  input  wire logic signed [SAMPLE_BITS-1:0] audio_in,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out
);
  import mdc_pkg::*;

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int CW    = $clog2(DELAY_DEPTH + 1);
  localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW    = 30 + IW;
  localparam int ACC_W = SAMPLE_BITS + WT_W + 2;
  localparam logic signed [DELAY_W-1:0] DLY_LO = DELAY_W'(longint'(2) << FRAC_BITS);
  localparam logic signed [DELAY_W-1:0] DLY_HI =
    DELAY_W'(longint'(DELAY_DEPTH - 3) << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] S_MAX =
    ACC_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(longint'(1) << 29);

  // constant quarter-wave sine table
  logic [LFO_BITS-1:0] sine_rom [0:SINE_TABLE_DEPTH];
  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_sine
    localparam logic [63:0] XQ30 = (64'(gi) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign sine_rom[gi] = sine_entry(XQ30);
  end

  logic [SAMPLE_BITS-1:0] ring_mem [0:DELAY_DEPTH-1];

  logic [AW-1:0]                wp_r, wr_idx_r;
  logic [CW-1:0]                fill_r;
  logic [31:0]                  phase_r;
  logic signed [SAMPLE_BITS-1:0] x_r, wet_r, left_r, right_r;
  logic [IW-1:0]                sine_addr_r;
  logic [1:0]                   quad_r;
  logic signed [LFO_BITS-1:0]   tri_r, lfo_r;
  logic signed [42:0]           prod_r;
  logic [AW-1:0]                id_r;
  logic [FRAC_BITS-1:0]         a_r;
  logic [32:0]                  ad1_r;
  logic [34:0]                  sd2_r;
  logic [31:0]                  m1_mag_r, w2_mag_r;
  logic signed [WT_W-1:0]       w_r [0:TAPS-1];
  logic [SAMPLE_BITS-1:0]       rd_data_r;
  logic                         tap_ok_r;
  logic signed [ACC_W-1:0]      acc_r;

  // combinational helpers
  logic [PW-1:0]               idx_prod;
  logic [IW-1:0]               idx_raw;
  logic signed [18:0]          tri_p, tri_v;
  logic signed [DELAY_W-1:0]   dly_sum, dly_cl;
  logic [16:0]                 d1, s1;
  logic [17:0]                 d2;
  logic [51:0]                 big_prod;
  logic [63:0]                 div_prod;
  logic [AW:0]                 tap_k, tap_sub;
  logic [AW-1:0]               rd_addr;
  logic                        tap_ok;
  logic signed [ACC_W-1:0]     mac_prod, rnd;
  logic signed [SAMPLE_BITS-1:0] tap_val, rnd_sat;

  assign sts.bypass = (cfg.effect_mode == EFFECT_BYPASS);
  assign left_out   = left_r;
  assign right_out  = right_r;

  // LFO index and triangle
  assign idx_prod = PW'(phase_r[29:0]) * PW'(SINE_TABLE_DEPTH);
  assign idx_raw  = idx_prod[PW-1:30];
  assign tri_p    = $signed({2'b00, phase_r[31:15]});
  always_comb begin
    case (phase_r[31:30])
      2'd0:    tri_v = tri_p;
      2'd3:    tri_v = tri_p - 19'sd131072;
      default: tri_v = 19'sd65536 - tri_p;
    endcase
  end

  // delay sum and clamp
  assign dly_sum = $signed(DELAY_W'(cfg.base_delay)) + DELAY_W'(prod_r >>> 15);
  always_comb begin
    if (dly_sum < DLY_LO) begin
      dly_cl = DLY_LO;
    end else if (dly_sum > DLY_HI) begin
      dly_cl = DLY_HI;
    end else begin
      dly_cl = dly_sum;
    end
  end

  // Lagrange factor magnitudes: 1-a, 2-a, 1+a
  assign d1 = 17'h10000 - 17'(a_r);
  assign d2 = 18'h20000 - 18'(a_r);
  assign s1 = 17'h10000 + 17'(a_r);

  always_comb begin
    case (cmd.op)
      OP_WM1:  big_prod = 52'(ad1_r) * 52'(d2);
      OP_W0:   big_prod = 52'(sd2_r) * 52'(d1);
      OP_W1:   big_prod = 52'(sd2_r) * 52'(a_r);
      default: big_prod = 52'(ad1_r) * 52'(s1);
    endcase
  end

  // divide by three by reciprocal, exact below 2^32
  assign div_prod = 64'((cmd.op == OP_DIV_M1) ? m1_mag_r : w2_mag_r) * 64'(RECIP3);

  // tap address: k samples back from the slot just written
  assign tap_k   = (AW+1)'(id_r) + (AW+1)'(cmd.rd_sel) - (AW+1)'(1);
  assign tap_sub = (AW+1)'(wr_idx_r) - tap_k;
  assign rd_addr = ({1'b0, wr_idx_r} >= tap_k) ? tap_sub[AW-1:0]
                   : AW'(tap_sub + (AW+1)'(DELAY_DEPTH));
  assign tap_ok  = 32'(tap_k) < 32'(fill_r);

  assign tap_val  = tap_ok_r ? $signed(rd_data_r) : '0;
  assign mac_prod = ACC_W'(w_r[cmd.mac_sel]) * ACC_W'(tap_val);

  assign rnd = (acc_r + RND_HALF) >>> 30;
  always_comb begin
    if (rnd > S_MAX) begin
      rnd_sat = S_MAX[SAMPLE_BITS-1:0];
    end else if (rnd < S_MIN) begin
      rnd_sat = S_MIN[SAMPLE_BITS-1:0];
    end else begin
      rnd_sat = rnd[SAMPLE_BITS-1:0];
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      ring_mem[wp_r] <= audio_in;
    end
    if (cmd.rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      fill_r  <= '0;
      phase_r <= '0;
    end else begin
      if (cmd.op == OP_ACCEPT) begin
        wp_r <= (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
        if (fill_r != CW'(DELAY_DEPTH)) begin
          fill_r <= fill_r + CW'(1);
        end
      end
      if (cmd.op == OP_FIN && !sts.bypass) begin
        phase_r <= phase_r + {1'b0, cfg.phase_step};
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      tap_ok_r <= tap_ok;
    end
    if (cmd.mac_en) begin
      acc_r <= acc_r + mac_prod;
    end
    case (cmd.op)
      OP_ACCEPT: begin
        x_r      <= audio_in;
        wr_idx_r <= wp_r;
      end
      OP_LFO_IDX: begin
        sine_addr_r <= phase_r[30] ? IW'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
        quad_r      <= phase_r[31:30];
        tri_r       <= (tri_v > 19'sd32767) ? 16'sd32767 : tri_v[LFO_BITS-1:0];
      end
      OP_LFO_VAL: begin
        if (cfg.wave_shape) begin
          lfo_r <= tri_r;
        end else if (quad_r[1]) begin
          lfo_r <= -$signed(sine_rom[sine_addr_r]);
        end else begin
          lfo_r <= $signed(sine_rom[sine_addr_r]);
        end
      end
      OP_SWEEP: prod_r <= 43'($signed({1'b0, cfg.sweep_depth}) * lfo_r);
      OP_DELAY: begin
        id_r  <= dly_cl[FRAC_BITS+AW-1:FRAC_BITS];
        a_r   <= dly_cl[FRAC_BITS-1:0];
        acc_r <= '0;
      end
      OP_PAIR_A: ad1_r <= 33'(a_r) * 33'(d1);
      OP_PAIR_B: sd2_r <= 35'(s1) * 35'(d2);
      OP_WM1:    m1_mag_r <= big_prod[50:19];
      OP_W0:     w_r[1] <= $signed(big_prod[50:19]);
      OP_W1:     w_r[2] <= $signed(big_prod[50:19]);
      OP_W2:     w2_mag_r <= big_prod[50:19];
      OP_DIV_M1: w_r[0] <= -$signed({1'b0, div_prod[63:33]});
      OP_DIV_W2: w_r[3] <= -$signed({1'b0, div_prod[63:33]});
      OP_ROUND:  wet_r <= rnd_sat;
      OP_FIN: begin
        if (sts.bypass) begin
          left_r  <= x_r;
          right_r <= x_r;
        end else begin
          left_r  <= (cfg.effect_mode == EFFECT_DRY_WET) ? x_r : wet_r;
          right_r <= wet_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/modulated_delay_chorus.sv]
// Sequence: off mode goes from accepting the input beat straight to the result state;
// chorus/vibrato first steps through LFO, sweep, delay, weight, divide, tap and round.
// Throughput: one beat in flight; next input taken the cycle after the result is
// registered. Micro-op sequence: one multiplier step per state, one ring read per tap.
// Reset (rst_n low, synchronous): ring fill count, write pointer, LFO phase, state
// machine and registers go to defaults; unwritten ring slots read as zero.
`default_nettype none
module modulated_delay_chorus #(
  parameter int DELAY_DEPTH      = 1024,
  parameter int SAMPLE_BITS      = 24,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input sample beats
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_audio_in,
  // stereo result beats
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_left_out,
  output logic signed [SAMPLE_BITS-1:0]      out_right_out,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mdc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import mdc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file: mode, waveform, centre delay, sweep, phase increment
  mdc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: owns both handshakes and the output-valid flag
  mdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: ring, LFO, 4-point Lagrange read, output register
  mdc_dp #(
    .DELAY_DEPTH      (DELAY_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .audio_in  (in_audio_in),
    .left_out  (out_left_out),
    .right_out (out_right_out)
  );

endmodule
`default_nettype wire

[rtl/mdc_checker.sv]
// Port-level checker for the chorus block, bound to the top level.
`default_nettype none
module mdc_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] out_left_out,
  input wire logic [SAMPLE_BITS-1:0] out_right_out
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_out)
      && $stable(out_right_out))
    else $error("result beat changed while stalled");

  // one item at a time: no input taken straight after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a new result never appears while the input side is open
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a sample in work");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind modulated_delay_chorus mdc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_left_out  (out_left_out),
  .out_right_out (out_right_out)
);
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the modulated delay chorus block.
`default_nettype none
module tb;
  import mdc_pkg::*;

  localparam int RING     = 1024;
  localparam int SBITS    = 24;
  localparam int QTR      = 256;
  localparam int LIMIT    = 400000;
  localparam int SETTLE   = 30;                // a little over the wet latency
  localparam longint SMAX = (64'sd1 <<< (SBITS - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef struct {
    logic signed [SBITS-1:0] left;
    logic signed [SBITS-1:0] right;
  } stereo_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [SBITS-1:0] in_audio_in, out_left_out, out_right_out;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  modulated_delay_chorus dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_audio_in(in_audio_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Local copy of the block's state and registers
  logic signed [SBITS-1:0] ring [RING];
  int unsigned   wr_ptr;
  logic [31:0]   phase;
  logic [1:0]    m_mode;
  logic          m_wave;
  logic [25:0]   m_base, m_sweep;
  logic [30:0]   m_step;
  longint        quarter_sine [QTR + 1];

  logic signed [SBITS-1:0] samples_due [$];
  stereo_t                 stereo_due [$];
  int      issued, taken, errors, cycles;
  bit      calm;        // no idling on either side
  int      gap, stall;

  // Quarter-wave sine in Q1.15 from a Q30 Taylor series up to x^13
  task automatic build_quarter_sine();
    logic [63:0] x, term;
    longint      acc, v;
    for (int i = 0; i <= QTR; i++) begin
      x    = (64'(i) * HALF_PI_Q30) / QTR;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / (64'(2 * k) * 64'(2 * k + 1));
        acc  = (k % 2) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = longint'(((64'(acc) << 15) + (64'd1 << 29)) >> 30);
      quarter_sine[i] = (v > 32767) ? 32767 : v;
    end
  endtask

  function automatic longint lfo_now();
    logic [1:0] q;
    longint     p, v;
    int         idx;
    q = phase[31:30];
    if (m_wave) begin
      p = longint'(phase >> 15);
      if (q == 2'd0) v = p;
      else if (q == 2'd3) v = p - 131072;
      else v = 65536 - p;
      return (v > 32767) ? 32767 : v;
    end
    idx = int'(phase[29:22]);
    if (q[0]) idx = QTR - idx;
    return q[1] ? -quarter_sine[idx] : quarter_sine[idx];
  endfunction

  function automatic longint ring_at(int k);
    return longint'(ring[(wr_ptr + RING - k) % RING]);
  endfunction

  // Interpolated read at the current modulated delay
  function automatic longint wet_now();
    longint f, dv, dl, a, wm1, w0, w1, w2, s, r;
    int id;
    f  = 65536;
    dv = 6 * 262144;
    dl = longint'(m_base) + ((longint'(m_sweep) * lfo_now()) >>> 15);
    if (dl < (64'sd2 <<< 16)) dl = 64'sd2 <<< 16;
    if (dl > (longint'(RING - 3) <<< 16)) dl = longint'(RING - 3) <<< 16;
    id  = int'(dl >>> 16);
    a   = dl & 64'hFFFF;
    wm1 = -(a * (a - f) * (a - 2 * f)) / dv;
    w0  = (3 * (a + f) * (a - f) * (a - 2 * f)) / dv;
    w1  = -(3 * (a + f) * a * (a - 2 * f)) / dv;
    w2  = ((a + f) * a * (a - f)) / dv;
    s   = wm1 * ring_at(id - 1) + w0 * ring_at(id) + w1 * ring_at(id + 1)
        + w2 * ring_at(id + 2);
    r   = (s + (64'sd1 <<< 29)) >>> 30;
    if (r > SMAX) r = SMAX;
    if (r < SMIN) r = SMIN;
    return r;
  endfunction

  // Advance the local model by one input beat and queue its stereo result
  task automatic mix_sample(input logic signed [SBITS-1:0] x);
    stereo_t o;
    longint  wet;
    ring[wr_ptr] = x;
    if (m_mode == EFFECT_BYPASS) begin
      o.left  = x;
      o.right = x;
    end else begin
      wet     = wet_now();
      o.right = wet[SBITS-1:0];
      o.left  = (m_mode == EFFECT_DRY_WET) ? x : wet[SBITS-1:0];
      phase   = phase + 32'(m_step);
    end
    wr_ptr = (wr_ptr + 1) % RING;
    stereo_due.push_back(o);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, stereo_due.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // Driver: sample beats from samples_due
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_audio_in <= '0;
      gap         = 0;
    end else begin
      if (in_valid && in_ready) begin
        mix_sample(in_audio_in);
        taken++;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (samples_due.size() > 0) begin
          in_audio_in <= samples_due.pop_front();
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    stereo_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall     = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (stereo_due.size() == 0) begin
          $display("%0t: unexpected beat L=%0d R=%0d", $time, out_left_out, out_right_out);
          errors++;
        end else begin
          e = stereo_due.pop_front();
          if (out_left_out !== e.left) begin
            $display("%0t: left expected %0d actual %0d", $time, e.left, out_left_out);
            errors++;
          end
          if (out_right_out !== e.right) begin
            $display("%0t: right expected %0d actual %0d", $time, e.right, out_right_out);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 5);
      end
    end
  end

  task automatic push_sample(input logic signed [SBITS-1:0] x);
    samples_due.push_back(x);
    issued++;
  endtask

  // Extremes and small values weighted up, the rest full-range random
  function automatic logic signed [SBITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SMAX[SBITS-1:0];
      1: return SMIN[SBITS-1:0];
      2: return SBITS'($signed($urandom_range(0, 64)) - 32);
      default: return SBITS'($urandom);
    endcase
  endfunction

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (taken != issued || stereo_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t r, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_MODE:  m_mode  = v[1:0];
      REG_WAVE:  m_wave  = v[0];
      REG_BASE:  m_base  = v[25:0];
      REG_SWEEP: m_sweep = v[25:0];
      REG_STEP:  m_step  = v[30:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [1:0] md, input logic wv, input logic [25:0] bs,
                         input logic [25:0] sw, input logic [30:0] st);
    reg_write(REG_MODE, 32'(md));
    reg_write(REG_WAVE, 32'(wv));
    reg_write(REG_BASE, 32'(bs));
    reg_write(REG_SWEEP, 32'(sw));
    reg_write(REG_STEP, 32'(st));
  endtask

  // Unlisted index: write lands nowhere, so the model is left alone
  task automatic stray_write(input logic [APB_AW-1:0] a);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= $urandom;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  initial begin
    logic [25:0] bs, sw;
    logic [30:0] st;
    int n;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; in_audio_in = '0; out_ready = 1'b0;
    issued = 0; taken = 0; errors = 0; cycles = 0; calm = 1'b0;
    foreach (ring[i]) ring[i] = '0;
    wr_ptr = 0; phase = '0;
    m_mode = EFFECT_BYPASS; m_wave = 1'b0; m_base = 26'd15728640; m_sweep = '0;
    m_step = 31'd44238;
    build_quarter_sine();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Off mode at reset values: extremes pass straight through
    push_sample(SMAX[SBITS-1:0]); push_sample(SMIN[SBITS-1:0]);
    push_sample('0); push_sample(-1); push_sample(1);
    for (int i = 0; i < 5; i++) push_sample(pick_sample());
    drain();

    // Chorus, zero base: delay clamps at its floor; alternating peaks are driven
    set_all(EFFECT_DRY_WET, 1'b0, '0, '0, '0);
    for (int i = 0; i < 5; i++) push_sample(i % 2 ? SMIN[SBITS-1:0] : SMAX[SBITS-1:0]);
    drain();
    // Vibrato, everything at full scale: delay clamps at its ceiling
    set_all(EFFECT_WET_BOTH, 1'b1, '1, '1, '1);
    for (int i = 0; i < 5; i++) push_sample(pick_sample());
    drain();
    // Mode three behaves as vibrato; stray addresses must be ignored
    set_all(EFFECT_SPARE, 1'b0, 26'd240 << 16, 26'd200 << 16, 31'h2000_0123);
    stray_write(APB_AW'(20));
    stray_write(APB_AW'(28));
    for (int i = 0; i < 5; i++) push_sample(pick_sample());
    drain();

    // Random phases; each boundary also holds the sender until results drain
    for (int ph = 0; ph < 13; ph++) begin
      bs = ($urandom_range(0, 5) == 0) ? 26'($urandom)
                                       : 26'($urandom_range(2 << 16, 1021 << 16));
      sw = ($urandom_range(0, 5) == 0) ? 26'($urandom)
                                       : 26'($urandom_range(0, 600 << 16));
      st = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 26));
      set_all(2'($urandom_range(0, 3)), 1'($urandom), bs, sw, st);
      if (ph == 12) calm = 1'b1;
      n = 150;
      for (int i = 0; i < n; i++) push_sample(pick_sample());
      drain();
    end

    if (stereo_due.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
